/* design/led_blink_pattern_with_timer_bank_core_macros.svh */
// Assertion helpers for the LED blink / timer bank block.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef LED_BLINK_PATTERN_WITH_TIMER_BANK_CORE_MACROS_SVH
`define LED_BLINK_PATTERN_WITH_TIMER_BANK_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LBP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LBP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LBP_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define LBP_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* design/lbp_pkg.sv */
`default_nettype none

package lbp_pkg;

  // timer bank size and the timer used by the action trigger
  localparam int NUM_TIMERS   = 10;
  localparam int ACTION_TIMER = 0;
  localparam int TIMER_IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam bit ACTION_VALID = (ACTION_TIMER < NUM_TIMERS);

  // fixed field widths
  localparam int TICK_W    = 16;
  localparam int MODE_W    = 3;
  localparam int INDEX_W   = 4;
  localparam int PATTERN_W = 3;
  localparam int CFG_IDX_W = 3;

  // item opcodes (6 and 7 do nothing)
  typedef enum logic [MODE_W-1:0] {
    MODE_TIMER_TICK  = 3'd0,
    MODE_LED_TICK    = 3'd1,
    MODE_SET_TIMER   = 3'd2,
    MODE_READ_TIMER  = 3'd3,
    MODE_SET_PATTERN = 3'd4,
    MODE_ACTION      = 3'd5
  } mode_t;

  // LED pattern codes
  typedef enum logic [PATTERN_W-1:0] {
    PAT_OFF     = 3'd0,
    PAT_ON      = 3'd1,
    PAT_SLOW    = 3'd2,
    PAT_FAST    = 3'd3,
    PAT_INVERSE = 3'd4
  } pattern_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOW_ON     = 3'd0,
    REG_SLOW_OFF    = 3'd1,
    REG_FAST_ON     = 3'd2,
    REG_FAST_OFF    = 3'd3,
    REG_INVERSE_ON  = 3'd4,
    REG_INVERSE_OFF = 3'd5,
    REG_ACTION      = 3'd6
  } reg_idx_t;

  // register reset values
  localparam logic [TICK_W-1:0] RST_SLOW_ON     = 16'd50;
  localparam logic [TICK_W-1:0] RST_SLOW_OFF    = 16'd750;
  localparam logic [TICK_W-1:0] RST_FAST_ON     = 16'd50;
  localparam logic [TICK_W-1:0] RST_FAST_OFF    = 16'd50;
  localparam logic [TICK_W-1:0] RST_INVERSE_ON  = 16'd750;
  localparam logic [TICK_W-1:0] RST_INVERSE_OFF = 16'd50;
  localparam logic [TICK_W-1:0] RST_ACTION      = 16'd800;

  // configuration register file contents
  typedef struct packed {
    logic [TICK_W-1:0] slow_on;
    logic [TICK_W-1:0] slow_off;
    logic [TICK_W-1:0] fast_on;
    logic [TICK_W-1:0] fast_off;
    logic [TICK_W-1:0] inverse_on;
    logic [TICK_W-1:0] inverse_off;
    logic [TICK_W-1:0] action;
  } cfg_t;

  // decoded one-hot operation for the word being processed this cycle
  typedef struct packed {
    logic timer_tick;
    logic led_tick;
    logic set_timer;
    logic read_timer;
    logic set_pattern;
    logic action;
  } cmd_t;

endpackage

`default_nettype wire

/* design/lbp_timer_bank.sv */
`default_nettype none
`include "led_blink_pattern_with_timer_bank_core_macros.svh"

module lbp_timer_bank (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lbp_pkg::cmd_t                 cmd,
  input  wire logic [lbp_pkg::INDEX_W-1:0]   timer_index,
  input  wire logic [lbp_pkg::TICK_W-1:0]    timer_load,
  input  wire logic [lbp_pkg::TICK_W-1:0]    action_load,
  output logic      [lbp_pkg::TICK_W-1:0]    rd_value,
  output logic                               action_zero
);

  logic [lbp_pkg::TICK_W-1:0]      cnt      [lbp_pkg::NUM_TIMERS];
  logic [lbp_pkg::TICK_W-1:0]      cnt_next [lbp_pkg::NUM_TIMERS];
  logic [lbp_pkg::TIMER_IDX_W-1:0] idx;
  logic                            hit;

  assign idx = lbp_pkg::TIMER_IDX_W'(timer_index);
  assign hit = (32'(timer_index) < lbp_pkg::NUM_TIMERS);

  // all timers update in parallel: tick, single write, action load
  always_comb begin
    for (int i = 0; i < lbp_pkg::NUM_TIMERS; i++) begin
      cnt_next[i] = cnt[i];
      if (cmd.timer_tick && (cnt[i] != '0)) begin
        cnt_next[i] = cnt[i] - lbp_pkg::TICK_W'(1);
      end
      if (cmd.set_timer && hit && (idx == lbp_pkg::TIMER_IDX_W'(i))) begin
        cnt_next[i] = timer_load;
      end
      if (cmd.action && lbp_pkg::ACTION_VALID && (i == lbp_pkg::ACTION_TIMER)) begin
        cnt_next[i] = action_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < lbp_pkg::NUM_TIMERS; i++) begin
      if (rst) begin
        cnt[i] <= '0;
      end else begin
        cnt[i] <= cnt_next[i];
      end
    end
  end

  // read port, zero when not a read or out of range
  assign rd_value = (cmd.read_timer && hit) ? cnt[idx] : '0;

  // action timer probe; a missing timer reads as zero
  generate
    if (lbp_pkg::ACTION_VALID) begin : g_act
      assign action_zero = (cnt[lbp_pkg::ACTION_TIMER] == '0);
    end else begin : g_noact
      assign action_zero = 1'b1;
    end
  endgenerate

  `LBP_ASSERT_IMP(a_rd_zero, clk, rst, !cmd.read_timer, rd_value == '0, "read data without read")
  `LBP_ASSERT_NXT(a_act_load, clk, rst, cmd.action && lbp_pkg::ACTION_VALID && (action_load != '0), !action_zero, "action timer not loaded")
  `LBP_ASSERT_NXT(a_tick_zero, clk, rst, cmd.timer_tick && action_zero, action_zero, "zero timer moved on tick")

endmodule

`default_nettype wire

/* design/lbp_led_ctrl.sv */
`default_nettype none
`include "led_blink_pattern_with_timer_bank_core_macros.svh"

module lbp_led_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire lbp_pkg::cmd_t                  cmd,
  input  wire logic [lbp_pkg::PATTERN_W-1:0]  pattern,
  input  wire lbp_pkg::cfg_t                  cfg,
  input  wire logic                           action_zero,
  output logic                                pin_next
);

  lbp_pkg::pattern_t          cur_pat, cur_pat_next;
  lbp_pkg::pattern_t          rem_pat, rem_pat_next;
  logic [lbp_pkg::TICK_W-1:0] led_cnt, led_cnt_next;
  logic                       act, act_next;
  logic                       pin;
  logic [lbp_pkg::TICK_W-1:0] on_t, off_t;

  // durations of the current blink pattern
  always_comb begin
    case (cur_pat)
      lbp_pkg::PAT_SLOW: begin
        on_t  = cfg.slow_on;
        off_t = cfg.slow_off;
      end
      lbp_pkg::PAT_FAST: begin
        on_t  = cfg.fast_on;
        off_t = cfg.fast_off;
      end
      default: begin
        on_t  = cfg.inverse_on;
        off_t = cfg.inverse_off;
      end
    endcase
  end

  // pattern state and LED next values
  always_comb begin
    cur_pat_next = cur_pat;
    rem_pat_next = rem_pat;
    led_cnt_next = led_cnt;
    act_next     = act;
    pin_next     = pin;
    if (cmd.led_tick) begin
      case (cur_pat)
        lbp_pkg::PAT_OFF: pin_next = 1'b1;
        lbp_pkg::PAT_ON:  pin_next = 1'b0;
        default: begin
          if (led_cnt != '0) begin
            led_cnt_next = led_cnt - lbp_pkg::TICK_W'(1);
          end else begin
            led_cnt_next = pin ? on_t : off_t;
            pin_next     = ~pin;
            // action over: go back to the remembered pattern
            if (act && action_zero) begin
              act_next     = 1'b0;
              led_cnt_next = '0;
              cur_pat_next = rem_pat;
            end
          end
        end
      endcase
    end
    if (cmd.set_pattern && (pattern <= lbp_pkg::PAT_INVERSE)) begin
      cur_pat_next = lbp_pkg::pattern_t'(pattern);
      if (pattern != lbp_pkg::PAT_FAST) begin
        rem_pat_next = lbp_pkg::pattern_t'(pattern);
      end
    end
    if (cmd.action) begin
      led_cnt_next = '0;
      act_next     = 1'b1;
      cur_pat_next = lbp_pkg::PAT_FAST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_pat <= lbp_pkg::PAT_SLOW;
      rem_pat <= lbp_pkg::PAT_SLOW;
      led_cnt <= '0;
      act     <= 1'b0;
      pin     <= 1'b1;
    end else begin
      cur_pat <= cur_pat_next;
      rem_pat <= rem_pat_next;
      led_cnt <= led_cnt_next;
      act     <= act_next;
      pin     <= pin_next;
    end
  end

  `LBP_ASSERT_IMP(a_rem_not_fast, clk, rst, 1'b1, rem_pat != lbp_pkg::PAT_FAST, "fast blink remembered")
  `LBP_ASSERT_NXT(a_off_dark, clk, rst, cmd.led_tick && (cur_pat == lbp_pkg::PAT_OFF), pin, "off pattern lit the LED")
  `LBP_ASSERT_NXT(a_action_fast, clk, rst, cmd.action, act && (cur_pat == lbp_pkg::PAT_FAST) && (led_cnt == '0), "action did not force fast blink")

endmodule

`default_nettype wire

/* design/led_blink_pattern_with_timer_bank_core.sv */
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_stall    | mode, timer_index, timer_load, pattern
// out     | output    | out_valid / out_stall  | led_pin, read_value
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word per cycle sustained while out_stall is low; each word passes the input register,
// then the single combinational pass over timers and LED state into the result register.
// Reset (rst, synchronous) clears all timers, LED state and loads register defaults.
// out_stall holds the result register; the input register keeps accepting while
// it drains, and in_stall rises only when both registers are full and blocked.
// cfg_ready is always high.
`default_nettype none
`include "led_blink_pattern_with_timer_bank_core_macros.svh"

module led_blink_pattern_with_timer_bank_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [lbp_pkg::MODE_W-1:0]       mode,
  input  wire logic [lbp_pkg::INDEX_W-1:0]      timer_index,
  input  wire logic [lbp_pkg::TICK_W-1:0]       timer_load,
  input  wire logic [lbp_pkg::PATTERN_W-1:0]    pattern,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  led_pin,
  output logic      [lbp_pkg::TICK_W-1:0]       read_value,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lbp_pkg::TICK_W-1:0]       cfg_data
);

  lbp_pkg::cfg_t                  cfg;
  lbp_pkg::cmd_t                  cmd;
  logic                           s1_valid;
  logic [lbp_pkg::MODE_W-1:0]     s1_mode;
  logic [lbp_pkg::INDEX_W-1:0]    s1_index;
  logic [lbp_pkg::TICK_W-1:0]     s1_load;
  logic [lbp_pkg::PATTERN_W-1:0]  s1_pattern;
  logic                           advance;
  logic                           in_take;
  logic                           pin_next;
  logic                           action_zero;
  logic [lbp_pkg::TICK_W-1:0]     rd_value;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slow_on     <= lbp_pkg::RST_SLOW_ON;
      cfg.slow_off    <= lbp_pkg::RST_SLOW_OFF;
      cfg.fast_on     <= lbp_pkg::RST_FAST_ON;
      cfg.fast_off    <= lbp_pkg::RST_FAST_OFF;
      cfg.inverse_on  <= lbp_pkg::RST_INVERSE_ON;
      cfg.inverse_off <= lbp_pkg::RST_INVERSE_OFF;
      cfg.action      <= lbp_pkg::RST_ACTION;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lbp_pkg::REG_SLOW_ON:     cfg.slow_on     <= cfg_data;
        lbp_pkg::REG_SLOW_OFF:    cfg.slow_off    <= cfg_data;
        lbp_pkg::REG_FAST_ON:     cfg.fast_on     <= cfg_data;
        lbp_pkg::REG_FAST_OFF:    cfg.fast_off    <= cfg_data;
        lbp_pkg::REG_INVERSE_ON:  cfg.inverse_on  <= cfg_data;
        lbp_pkg::REG_INVERSE_OFF: cfg.inverse_off <= cfg_data;
        lbp_pkg::REG_ACTION:      cfg.action      <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage handshake: process when the result register can take a word
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take || advance) begin
      s1_valid <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode    <= mode;
      s1_index   <= timer_index;
      s1_load    <= timer_load;
      s1_pattern <= pattern;
    end
  end

  // opcode decode, only on the cycle the word is processed
  always_comb begin
    cmd = '0;
    if (advance) begin
      case (s1_mode)
        lbp_pkg::MODE_TIMER_TICK:  cmd.timer_tick  = 1'b1;
        lbp_pkg::MODE_LED_TICK:    cmd.led_tick    = 1'b1;
        lbp_pkg::MODE_SET_TIMER:   cmd.set_timer   = 1'b1;
        lbp_pkg::MODE_READ_TIMER:  cmd.read_timer  = 1'b1;
        lbp_pkg::MODE_SET_PATTERN: cmd.set_pattern = 1'b1;
        lbp_pkg::MODE_ACTION:      cmd.action      = 1'b1;
        default: ;
      endcase
    end
  end

  lbp_timer_bank u_timers (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .timer_index (s1_index),
    .timer_load  (s1_load),
    .action_load (cfg.action),
    .rd_value    (rd_value),
    .action_zero (action_zero)
  );

  lbp_led_ctrl u_led (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .pattern     (s1_pattern),
    .cfg         (cfg),
    .action_zero (action_zero),
    .pin_next    (pin_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance || !out_stall) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_pin    <= pin_next;
      read_value <= rd_value;
    end
  end

  `LBP_ASSERT_NXT(a_adv_out, clk, rst, advance, out_valid, "processed word lost")
  `LBP_ASSERT_IMP(a_stall_full, clk, rst, in_stall, s1_valid && out_valid && out_stall, "stall without full pipe")
  `LBP_ASSERT_NXT(a_take_s1, clk, rst, in_take, s1_valid, "accepted word not held")

endmodule

`default_nettype wire

/* tb/tb_led_blink_pattern_with_timer_bank_core.sv */
module tb_led_blink_pattern_with_timer_bank_core;
  import lbp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_REGS    = int'(REG_ACTION) + 1;
  localparam int PHASE_WORDS = 310;

  // codes outside the defined sets
  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 3'd7;
  localparam logic [MODE_W-1:0]    MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0]    MODE_SPARE_HI = 3'd7;
  localparam logic [PATTERN_W-1:0] PAT_BAD_LO    = 3'd5;
  localparam logic [PATTERN_W-1:0] PAT_BAD_HI    = 3'd7;

  typedef enum int {DUR_SHORT, DUR_ZERO, DUR_MAX, DUR_MIXED} dur_kind_e;

  typedef struct packed {
    logic              led;
    logic [TICK_W-1:0] rd;
  } led_word_t;

  // Predicts pin level and read data of every word, checks results in order
  class blink_predictor;
    logic [TICK_W-1:0] timers [NUM_TIMERS];
    logic [TICK_W-1:0] durations [NUM_REGS];
    logic [TICK_W-1:0] led_cnt;
    pattern_t          cur;
    pattern_t          saved;
    logic              action_on;
    logic              pin;
    led_word_t         expected_words [$];
    int                errors;
    int                accepted;
    int                checked;
    int                toggles;
    int                restores;

    function new();
      foreach (timers[i]) timers[i] = '0;
      durations[REG_SLOW_ON]     = RST_SLOW_ON;
      durations[REG_SLOW_OFF]    = RST_SLOW_OFF;
      durations[REG_FAST_ON]     = RST_FAST_ON;
      durations[REG_FAST_OFF]    = RST_FAST_OFF;
      durations[REG_INVERSE_ON]  = RST_INVERSE_ON;
      durations[REG_INVERSE_OFF] = RST_INVERSE_OFF;
      durations[REG_ACTION]      = RST_ACTION;
      led_cnt   = '0;
      cur       = PAT_SLOW;
      saved     = PAT_SLOW;
      action_on = 1'b0;
      pin       = 1'b1;
      errors    = 0;
      accepted  = 0;
      checked   = 0;
      toggles   = 0;
      restores  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] data);
      if (idx <= REG_ACTION) durations[idx] = data;
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH %0d: %s", errors, msg);
    endfunction

    // fast blink is never remembered
    function void set_pattern(pattern_t p);
      cur = p;
      if (p != PAT_FAST) saved = p;
    endfunction

    function void led_tick();
      logic [TICK_W-1:0] on_t;
      logic [TICK_W-1:0] off_t;
      logic [TICK_W-1:0] act_t;
      case (cur)
        PAT_OFF: pin = 1'b1;
        PAT_ON:  pin = 1'b0;
        default: begin
          if (led_cnt != '0) begin
            led_cnt = led_cnt - 1'b1;
          end else begin
            case (cur)
              PAT_SLOW: begin
                on_t  = durations[REG_SLOW_ON];
                off_t = durations[REG_SLOW_OFF];
              end
              PAT_FAST: begin
                on_t  = durations[REG_FAST_ON];
                off_t = durations[REG_FAST_OFF];
              end
              default: begin
                on_t  = durations[REG_INVERSE_ON];
                off_t = durations[REG_INVERSE_OFF];
              end
            endcase
            // lit pin (0) loads the dark time and vice versa
            led_cnt = pin ? on_t : off_t;
            pin     = ~pin;
            toggles++;
            act_t = ACTION_VALID ? timers[ACTION_TIMER] : '0;
            if (action_on && act_t == '0) begin
              action_on = 1'b0;
              led_cnt   = '0;
              set_pattern(saved);
              restores++;
            end
          end
        end
      endcase
    endfunction

    function void accept_word(logic [MODE_W-1:0] m, logic [INDEX_W-1:0] ix,
                              logic [TICK_W-1:0] ld, logic [PATTERN_W-1:0] pt);
      led_word_t w;
      w.rd = '0;
      case (m)
        MODE_TIMER_TICK:
          foreach (timers[i]) if (timers[i] != '0) timers[i] = timers[i] - 1'b1;
        MODE_LED_TICK:    led_tick();
        MODE_SET_TIMER:   if (ix < NUM_TIMERS) timers[ix] = ld;
        MODE_READ_TIMER:  if (ix < NUM_TIMERS) w.rd = timers[ix];
        MODE_SET_PATTERN: if (pt <= PAT_INVERSE) set_pattern(pattern_t'(pt));
        MODE_ACTION: begin
          led_cnt   = '0;
          action_on = 1'b1;
          set_pattern(PAT_FAST);
          if (ACTION_VALID) timers[ACTION_TIMER] = durations[REG_ACTION];
        end
        default: ;
      endcase
      w.led = pin;
      expected_words.push_back(w);
      accepted++;
    endfunction

    function void check_word(logic led, logic [TICK_W-1:0] rd);
      led_word_t w;
      checked++;
      if (expected_words.size() == 0) begin
        note_error($sformatf("unexpected word: led_pin %0b read_value %h", led, rd));
        return;
      end
      w = expected_words.pop_front();
      if (led !== w.led)
        note_error($sformatf("word %0d led_pin expected %0b got %0b", checked, w.led, led));
      if (rd !== w.rd)
        note_error($sformatf("word %0d read_value expected %h got %h", checked, w.rd, rd));
    endfunction
  endclass

  logic                 clk;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [MODE_W-1:0]    mode        = '0;
  logic [INDEX_W-1:0]   timer_index = '0;
  logic [TICK_W-1:0]    timer_load  = '0;
  logic [PATTERN_W-1:0] pattern     = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic                 led_pin;
  logic [TICK_W-1:0]    read_value;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [TICK_W-1:0]    cfg_data    = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycles      = 0;

  blink_predictor bp = new();

  led_blink_pattern_with_timer_bank_core uut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) bp.check_word(led_pin, read_value);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one input word, with random gaps in front of it
  task automatic send_word(input logic [MODE_W-1:0] m, input logic [INDEX_W-1:0] ix,
                           input logic [TICK_W-1:0] ld, input logic [PATTERN_W-1:0] pt);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    timer_index <= ix;
    timer_load  <= ld;
    pattern     <= pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bp.accept_word(m, ix, ld, pt);
  endtask

  // caller lowers cfg_valid after the last write of a batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    bp.write_reg(idx, data);
  endtask

  // hold off input until every pending word has come back
  task automatic wait_idle(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (bp.expected_words.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  function automatic logic [TICK_W-1:0] pick_dur(dur_kind_e kind, reg_idx_t r);
    case (kind)
      DUR_ZERO:  return '0;
      DUR_MAX:   return '1;
      DUR_SHORT: return (r == REG_ACTION) ? TICK_W'($urandom_range(12))
                                          : TICK_W'($urandom_range(5));
      default:   return ($urandom_range(1) == 0) ? TICK_W'($urandom)
                                                 : TICK_W'($urandom_range(9));
    endcase
  endfunction

  // reprogram durations, then a block of random words
  task automatic run_phase(input dur_kind_e kind, input int tx_pct, input int rx_pct);
    logic [MODE_W-1:0]    m;
    logic [INDEX_W-1:0]   ix;
    logic [TICK_W-1:0]    ld;
    logic [PATTERN_W-1:0] pt;
    int                   r;
    wait_idle(4);
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(CFG_IDX_W'(i), pick_dur(kind, reg_idx_t'(i)));
    write_reg(REG_SPARE, TICK_W'($urandom));
    cfg_valid <= 1'b0;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int k = 0; k < PHASE_WORDS; k++) begin
      if (k == PHASE_WORDS / 2) wait_idle(0);
      r = $urandom_range(99);
      if (r < 35)      m = MODE_LED_TICK;
      else if (r < 55) m = MODE_TIMER_TICK;
      else if (r < 67) m = MODE_SET_TIMER;
      else if (r < 80) m = MODE_READ_TIMER;
      else if (r < 90) m = MODE_SET_PATTERN;
      else if (r < 96) m = MODE_ACTION;
      else             m = MODE_W'($urandom_range(7));
      // favor the action timer so restores actually happen
      if ($urandom_range(9) == 0)      ix = INDEX_W'($urandom_range(15));
      else if ($urandom_range(2) == 0) ix = INDEX_W'(ACTION_TIMER);
      else                             ix = INDEX_W'($urandom_range(NUM_TIMERS - 1));
      ld = ($urandom_range(7) == 0) ? TICK_W'($urandom) : TICK_W'($urandom_range(24));
      pt = ($urandom_range(9) == 0) ? PATTERN_W'($urandom_range(7))
                                    : PATTERN_W'($urandom_range(PAT_INVERSE));
      send_word(m, ix, ld, pt);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 32;
    rx_idle_pct = 58;

    // directed: timer bank edges
    send_word(MODE_READ_TIMER, INDEX_W'(ACTION_TIMER), '0, '0);
    send_word(MODE_READ_TIMER, '1, '0, '0);
    send_word(MODE_SET_TIMER, INDEX_W'(NUM_TIMERS - 1), '1, '0);
    send_word(MODE_READ_TIMER, INDEX_W'(NUM_TIMERS - 1), '0, '0);
    send_word(MODE_SET_TIMER, INDEX_W'(NUM_TIMERS), 16'h5a5a, '0);
    send_word(MODE_READ_TIMER, INDEX_W'(NUM_TIMERS), '0, '0);
    send_word(MODE_TIMER_TICK, '0, '0, '0);
    send_word(MODE_READ_TIMER, INDEX_W'(NUM_TIMERS - 1), '0, '0);
    // directed: every pattern, bad pattern codes, spare modes
    send_word(MODE_LED_TICK, '0, '0, '0);
    send_word(MODE_LED_TICK, '0, '0, '0);
    send_word(MODE_SET_PATTERN, '0, '0, PAT_OFF);
    send_word(MODE_LED_TICK, '0, '0, '0);
    send_word(MODE_SET_PATTERN, '0, '0, PAT_ON);
    send_word(MODE_LED_TICK, '0, '0, '0);
    send_word(MODE_SET_PATTERN, '0, '0, PAT_BAD_LO);
    send_word(MODE_SET_PATTERN, '0, '0, PAT_BAD_HI);
    send_word(MODE_SET_PATTERN, '0, '0, PAT_INVERSE);
    send_word(MODE_LED_TICK, '0, '0, '0);
    send_word(MODE_SPARE_LO, '1, '1, '1);
    send_word(MODE_SPARE_HI, '1, '1, '1);
    // directed: action trigger, fast blink while action is pending
    send_word(MODE_ACTION, '0, '0, '0);
    send_word(MODE_READ_TIMER, INDEX_W'(ACTION_TIMER), '0, '0);
    send_word(MODE_LED_TICK, '0, '0, '0);
    send_word(MODE_SET_PATTERN, '0, '0, PAT_FAST);
    send_word(MODE_SET_TIMER, INDEX_W'(ACTION_TIMER), '0, '0);

    run_phase(DUR_SHORT, 32, 58);
    run_phase(DUR_ZERO,  32, 58);
    run_phase(DUR_MAX,   58, 32);
    run_phase(DUR_SHORT, 58, 32);
    run_phase(DUR_MIXED,  0,  0);
    run_phase(DUR_SHORT,  0,  0);
    wait_idle(8);

    if (bp.expected_words.size() != 0) begin
      $display("%0d expected words never arrived", bp.expected_words.size());
      bp.errors += bp.expected_words.size();
    end
    $display("Covered %0d words in, %0d results checked over six duration settings",
             bp.accepted, bp.checked);
    $display("  incl. zero and full-scale durations; %0d LED toggles, %0d action restores",
             bp.toggles, bp.restores);
    if (bp.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
